>>> sv/psg_tone_noise_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// PSG assertion macros
// Concurrent assertion helpers clocked by i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_GENERATOR_UNIT_DEFINES_SVH
`define PSG_TONE_NOISE_GENERATOR_UNIT_DEFINES_SVH

// check a consequence in the same cycle
`define PSG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the following cycle
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/psg_pkg.sv
// ----------------------------------------------------------------------------
// PSG package
// Widths, codes and the attenuation level table of the tone/noise generator.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

    localparam int LEVEL_BITS = 16;
    localparam int LEVEL_W    = LEVEL_BITS - 1;
    localparam int SAMPLE_W   = 18;
    localparam int TONE_W     = 11;
    localparam int PERIOD_W   = 12;
    localparam int SHIFT_W    = 17;
    localparam int NUM_TONES  = 3;
    localparam int NUM_CHANS  = 4;

    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [TONE_W-1:0]   t_tone_period;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [SHIFT_W-1:0]  t_shift;
    typedef logic [3:0]          t_atten;
    typedef logic [1:0]          t_chan;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_MUTE  = 2'd2
    } t_op;

    localparam logic [2:0] REG_NOISE_CTRL = 3'd6;
    localparam t_chan      NOISE_CHAN     = 2'd3;
    localparam t_chan      TONE2_CHAN     = 2'd2;
    localparam logic [1:0] NOISE_FOLLOW   = 2'd3;
    localparam t_atten     ATTEN_SILENT   = 4'hF;
    localparam t_tone_period PERIOD_FULL  = 11'd1024;
    localparam t_period    NOISE_BASE     = 12'h020;
    localparam t_shift     SHIFT_RESET    = t_shift'(1) << (SHIFT_W - 1);

    function automatic t_level micro_to_level(input longint unsigned micro);
        return t_level'(((micro << LEVEL_BITS) + 64'd500000) / 64'd1000000);
    endfunction

    localparam t_level LEVEL_TABLE [16] = '{
        micro_to_level(64'd250000), micro_to_level(64'd198582),
        micro_to_level(64'd157739), micro_to_level(64'd125297),
        micro_to_level(64'd99527),  micro_to_level(64'd79057),
        micro_to_level(64'd62797),  micro_to_level(64'd49882),
        micro_to_level(64'd39622),  micro_to_level(64'd31473),
        micro_to_level(64'd25000),  micro_to_level(64'd19858),
        micro_to_level(64'd15774),  micro_to_level(64'd12530),
        micro_to_level(64'd9953),   micro_to_level(64'd0)
    };

    function automatic t_sample signed_term(input logic positive, input t_atten idx);
        t_sample mag;
        mag = SAMPLE_W'(LEVEL_TABLE[idx]);
        return positive ? mag : t_sample'(-mag);
    endfunction

endpackage

`default_nettype wire

>>> sv/psg_req_if.sv
// ----------------------------------------------------------------------------
// PSG request channel
// Valid/ready channel carrying one operation code and one write byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data;

    modport source (output valid, output op, output data, input ready);
    modport sink   (input valid, input op, input data, output ready);
endinterface

`default_nettype wire

>>> sv/psg_rsp_if.sv
// ----------------------------------------------------------------------------
// PSG sample channel
// Valid/ready channel carrying one signed mixed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> sv/psg_tone_noise_generator_unit.sv
// ----------------------------------------------------------------------------
// PSG tone and noise generator
// Three square-wave tones and one shift-register noise channel, mixed to one
// signed sample per tick request.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries requests: op write (data is a register byte), op tick
//   (advance all counters and produce one sample) or op mute (silence all
//   channels). Only tick requests produce an item on o_rsp.
//   o_rsp carries the 18-bit signed sum of the four channel levels.
//   A request is registered on acceptance and executed in the next stage; a
//   tick's sample is then held in the sample register that drives o_rsp.
//   One request is accepted every cycle while o_rsp does not stall; the state
//   update and the mix are combinational between request and sample registers.
//   When o_rsp stalls, the sample holds and one more request waits in the
//   request register; i_req.ready drops only once that register is full too.
//   Reset (i_rst_n low, synchronous) clears periods and counters, sets every
//   attenuation to silent and loads the noise register with its top bit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "psg_tone_noise_generator_unit_defines.svh"

module psg_tone_noise_generator_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    psg_req_if.sink   i_req,
    psg_rsp_if.source o_rsp
);

    logic       r_s1_valid;
    logic [1:0] r_op;
    logic [7:0] r_data;

    psg_pkg::t_tone_period r_tone_period [psg_pkg::NUM_TONES];
    psg_pkg::t_tone_period n_tone_period [psg_pkg::NUM_TONES];
    psg_pkg::t_period      r_noise_period, n_noise_period;
    logic [psg_pkg::NUM_TONES-1:0] r_square, n_square;
    psg_pkg::t_atten       r_atten [psg_pkg::NUM_CHANS];
    psg_pkg::t_atten       n_atten [psg_pkg::NUM_CHANS];
    psg_pkg::t_shift       r_shift, n_shift;
    logic [3:0]            r_low_nib, n_low_nib;
    psg_pkg::t_chan        r_latch_ch, n_latch_ch;
    logic                  r_follow, n_follow;
    logic                  r_white, n_white;

    logic                  r_out_valid;
    psg_pkg::t_sample      r_sample, n_sample;

    logic                  w_adv;
    logic                  w_proc;
    logic                  w_tick;
    logic [psg_pkg::NUM_CHANS-1:0] w_expire;
    logic [2:0]            w_reg;
    logic [9:0]            w_period_raw;
    psg_pkg::t_tone_period w_period;
    logic                  w_fb;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign w_proc      = r_s1_valid && w_adv;
    assign w_tick      = w_proc && (r_op == psg_pkg::OP_TICK);
    assign i_req.ready = !r_s1_valid || w_adv;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.sample = r_sample;

    for (genvar g = 0; g < psg_pkg::NUM_TONES; g++) begin : g_tone
        psg_counter u_tone_cnt (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (w_tick),
            .i_period (psg_pkg::t_period'(r_tone_period[g])),
            .o_expire (w_expire[g])
        );
    end

    psg_counter u_noise_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_tick),
        .i_period (r_noise_period),
        .o_expire (w_expire[psg_pkg::NOISE_CHAN])
    );

    assign w_reg        = r_data[6:4];
    assign w_period_raw = {r_data[5:0], r_low_nib};
    assign w_period     = (w_period_raw == '0) ? psg_pkg::PERIOD_FULL
                                               : psg_pkg::t_tone_period'(w_period_raw);
    assign w_fb         = r_shift[2] ^ (r_shift[3] & r_white);

    always_comb begin
        n_tone_period  = r_tone_period;
        n_noise_period = r_noise_period;
        n_square       = r_square;
        n_atten        = r_atten;
        n_shift        = r_shift;
        n_low_nib      = r_low_nib;
        n_latch_ch     = r_latch_ch;
        n_follow       = r_follow;
        n_white        = r_white;
        if (w_proc) begin
            unique case (r_op)
                psg_pkg::OP_WRITE: begin
                    if (r_data[7]) begin
                        n_latch_ch = w_reg[2:1];
                        if (w_reg == psg_pkg::REG_NOISE_CTRL) begin
                            n_follow = (r_data[1:0] == psg_pkg::NOISE_FOLLOW);
                            n_noise_period = n_follow
                                ? (psg_pkg::t_period'(r_tone_period[psg_pkg::TONE2_CHAN]) << 1)
                                : (psg_pkg::NOISE_BASE << r_data[1:0]);
                            n_white = r_data[2];
                        end else if (w_reg[0]) begin
                            n_atten[w_reg[2:1]] = r_data[3:0];
                        end else begin
                            n_low_nib = r_data[3:0];
                        end
                    end else if (r_latch_ch != psg_pkg::NOISE_CHAN) begin
                        n_tone_period[r_latch_ch] = w_period;
                        if (r_follow && r_latch_ch == psg_pkg::TONE2_CHAN) begin
                            n_noise_period = psg_pkg::t_period'(w_period) << 1;
                        end
                    end
                end
                psg_pkg::OP_TICK: begin
                    n_square = r_square ^ w_expire[psg_pkg::NUM_TONES-1:0];
                    if (w_expire[psg_pkg::NOISE_CHAN]) begin
                        n_shift = {w_fb, r_shift[psg_pkg::SHIFT_W-1:1]};
                    end
                end
                psg_pkg::OP_MUTE: begin
                    for (int i = 0; i < psg_pkg::NUM_CHANS; i++) begin
                        n_atten[i] = psg_pkg::ATTEN_SILENT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_sample = psg_pkg::signed_term(n_shift[0], r_atten[psg_pkg::NOISE_CHAN]);
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            n_sample = n_sample + psg_pkg::signed_term(n_square[i], r_atten[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op   <= i_req.op;
            r_data <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
                r_tone_period[i] <= '0;
            end
            for (int i = 0; i < psg_pkg::NUM_CHANS; i++) begin
                r_atten[i] <= psg_pkg::ATTEN_SILENT;
            end
            r_noise_period <= '0;
            r_square       <= '0;
            r_shift        <= psg_pkg::SHIFT_RESET;
            r_low_nib      <= '0;
            r_latch_ch     <= '0;
            r_follow       <= 1'b0;
            r_white        <= 1'b0;
        end else begin
            r_tone_period  <= n_tone_period;
            r_atten        <= n_atten;
            r_noise_period <= n_noise_period;
            r_square       <= n_square;
            r_shift        <= n_shift;
            r_low_nib      <= n_low_nib;
            r_latch_ch     <= n_latch_ch;
            r_follow       <= n_follow;
            r_white        <= n_white;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_sample <= n_sample;
        end
    end

    `PSG_ASSERT_SAME(a_ready_when_empty, !r_s1_valid, i_req.ready, "request stage empty but not ready")

    `PSG_ASSERT_NEXT(a_tick_gives_sample, w_tick, r_out_valid, "tick request produced no sample")

    `PSG_ASSERT_NEXT(a_mute_silences, w_proc && r_op == psg_pkg::OP_MUTE, (r_atten[0] == psg_pkg::ATTEN_SILENT) && (r_atten[1] == psg_pkg::ATTEN_SILENT) && (r_atten[2] == psg_pkg::ATTEN_SILENT) && (r_atten[3] == psg_pkg::ATTEN_SILENT), "mute left a channel audible")

    `PSG_ASSERT_NEXT(a_noise_follows_tone2, w_proc && r_op == psg_pkg::OP_WRITE && !r_data[7] && r_follow && r_latch_ch == psg_pkg::TONE2_CHAN, r_noise_period == (psg_pkg::t_period'(r_tone_period[psg_pkg::TONE2_CHAN]) << 1), "noise period not tracking tone 2")

endmodule

`default_nettype wire

>>> sv/psg_counter.sv
// ----------------------------------------------------------------------------
// PSG period counter
// Phase counter that flags expiry when the advanced count reaches or exceeds the period.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_counter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire psg_pkg::t_period  i_period,
    output logic                   o_expire
);

    psg_pkg::t_period r_phase;
    psg_pkg::t_period n_phase;
    psg_pkg::t_period w_inc;

    assign w_inc    = r_phase + psg_pkg::t_period'(1);
    assign o_expire = (w_inc >= i_period);

    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            n_phase = o_expire ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PSG tone and noise generator testbench
// Drives register writes, ticks, mutes and unused ops on the request channel
// and checks every mixed sample against a cycle-free model of the tone
// counters, noise shift register and attenuation levels kept in a scoreboard.
// ----------------------------------------------------------------------------

module tb;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 5;
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          MAX_GAP       = 18;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          TIMEOUT_NS    = 3_000_000;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [2:0]  REG_TONE0     = 3'd0;
    localparam logic [2:0]  REG_TONE1     = 3'd2;
    localparam logic [2:0]  REG_TONE2     = 3'd4;
    localparam logic [2:0]  REG_ATT0      = 3'd1;
    localparam logic [2:0]  REG_ATT1      = 3'd3;
    localparam logic [2:0]  REG_ATT2      = 3'd5;
    localparam logic [2:0]  REG_ATT_NOISE = 3'd7;

    localparam int unsigned AMP_MICRO [16] = '{
        250000, 198582, 157739, 125297, 99527, 79057, 62797, 49882,
        39622,  31473,  25000,  19858,  15774, 12530, 9953,  0
    };

    class psg_scoreboard;
        psg_pkg::t_tone_period tone_period [psg_pkg::NUM_TONES];
        psg_pkg::t_period      noise_period;
        psg_pkg::t_period      phase [psg_pkg::NUM_CHANS];
        logic                  square [psg_pkg::NUM_TONES];
        psg_pkg::t_atten       atten [psg_pkg::NUM_CHANS];
        psg_pkg::t_shift       noise_shift;
        logic [3:0]            low_nibble;
        psg_pkg::t_chan        latched_chan;
        logic                  noise_follows;
        logic                  white_mode;
        psg_pkg::t_level       amp [16];
        psg_pkg::t_sample      expected_q [$];
        int                    mismatches;
        int                    checked;

        function new();
            for (int i = 0; i < 16; i++) begin
                amp[i] = psg_pkg::t_level'(
                    ((longint'(AMP_MICRO[i]) << psg_pkg::LEVEL_BITS) + 500000) / 1000000);
            end
            for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
                tone_period[i] = '0;
                square[i]      = 1'b0;
            end
            for (int i = 0; i < psg_pkg::NUM_CHANS; i++) begin
                phase[i] = '0;
                atten[i] = psg_pkg::ATTEN_SILENT;
            end
            noise_period  = '0;
            noise_shift   = psg_pkg::t_shift'(1) << (psg_pkg::SHIFT_W - 1);
            low_nibble    = '0;
            latched_chan  = '0;
            noise_follows = 1'b0;
            white_mode    = 1'b0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function void write_byte(logic [7:0] d);
            logic [2:0]            r;
            psg_pkg::t_tone_period p;
            if (d[7]) begin
                r            = d[6:4];
                latched_chan = r[2:1];
                if (r == psg_pkg::REG_NOISE_CTRL) begin
                    noise_follows = (d[1:0] == psg_pkg::NOISE_FOLLOW);
                    noise_period  = noise_follows
                        ? {tone_period[psg_pkg::TONE2_CHAN], 1'b0}
                        : psg_pkg::t_period'(psg_pkg::NOISE_BASE << d[1:0]);
                    white_mode    = d[2];
                end else if (r[0]) begin
                    atten[latched_chan] = d[3:0];
                end else begin
                    low_nibble = d[3:0];
                end
            end else if (latched_chan != psg_pkg::NOISE_CHAN) begin
                p = {1'b0, d[5:0], low_nibble};
                if (p == '0) p = psg_pkg::PERIOD_FULL;
                tone_period[latched_chan] = p;
                if (noise_follows && latched_chan == psg_pkg::TONE2_CHAN)
                    noise_period = {tone_period[psg_pkg::TONE2_CHAN], 1'b0};
            end
        endfunction

        function int signed_amp(logic positive, psg_pkg::t_atten idx);
            return positive ? int'(amp[idx]) : -int'(amp[idx]);
        endfunction

        function psg_pkg::t_sample mix_tick();
            int   sum;
            logic fb;
            sum = 0;
            for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
                phase[i] = phase[i] + 1;
                if (phase[i] >= psg_pkg::t_period'(tone_period[i])) begin
                    phase[i]  = '0;
                    square[i] = ~square[i];
                end
                sum += signed_amp(square[i], atten[i]);
            end
            phase[psg_pkg::NOISE_CHAN] = phase[psg_pkg::NOISE_CHAN] + 1;
            if (phase[psg_pkg::NOISE_CHAN] >= noise_period) begin
                fb          = noise_shift[2] ^ (noise_shift[3] & white_mode);
                phase[psg_pkg::NOISE_CHAN] = '0;
                noise_shift = {fb, noise_shift[psg_pkg::SHIFT_W-1:1]};
            end
            sum += signed_amp(noise_shift[0], atten[psg_pkg::NOISE_CHAN]);
            return psg_pkg::t_sample'(sum);
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] d);
            if (op == psg_pkg::OP_WRITE) begin
                write_byte(d);
            end else if (op == psg_pkg::OP_MUTE) begin
                for (int i = 0; i < psg_pkg::NUM_CHANS; i++) atten[i] = psg_pkg::ATTEN_SILENT;
            end else if (op == psg_pkg::OP_TICK) begin
                expected_q.push_back(mix_tick());
            end
        endfunction

        function void check_sample(psg_pkg::t_sample got);
            psg_pkg::t_sample want;
            if (expected_q.size() == 0) begin
                $error("sample: expected none, actual %0d", $signed(got));
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want) begin
                $error("sample: expected %0d, actual %0d", $signed(want), $signed(got));
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_off_req;
    bit   sender_burst;
    bit   receiver_burst;
    int   sent;
    int   ticks_sent;

    psg_req_if req ();
    psg_rsp_if rsp ();

    psg_scoreboard sb;

    psg_tone_noise_generator_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] latch_byte(logic [2:0] r, logic [3:0] nib);
        return {1'b1, r, nib};
    endfunction

    function automatic logic [2:0] tone_reg(int ch);
        return (ch == 0) ? REG_TONE0 : (ch == 1) ? REG_TONE1 : REG_TONE2;
    endfunction

    function automatic logic [2:0] atten_reg(int ch);
        case (ch)
            0: return REG_ATT0;
            1: return REG_ATT1;
            2: return REG_ATT2;
            default: return REG_ATT_NOISE;
        endcase
    endfunction

    task automatic send_req(input logic [1:0] op, input logic [7:0] d);
        int gap;
        if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.data  <= d;
        do @(posedge clk); while (req.ready !== 1'b1);
        sb.note_request(op, d);
        sent++;
        if (op == psg_pkg::OP_TICK) ticks_sent++;
    endtask

    task automatic send_tick();
        send_req(psg_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_tone_write(int ch, logic [3:0] nib, logic [6:0] hi);
        send_req(psg_pkg::OP_WRITE, latch_byte(tone_reg(ch), nib));
        send_req(psg_pkg::OP_WRITE, {1'b0, hi});
    endtask

    // sample receiver: random stalls, one long hold-off on request
    initial begin
        int  wait_cycles;
        bit  hold_done;
        hold_done = 1'b0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
            wait_cycles = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off_req && !hold_done) begin
                wait_cycles = HOLD_CYCLES;
                hold_done   = 1'b1;
            end
            if (wait_cycles > 0) begin
                rsp.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (rsp.valid !== 1'b1);
            sb.check_sample(rsp.sample);
        end
    end

    initial begin
        int kind;
        int ch;
        sb           = new();
        sent         = 0;
        ticks_sent   = 0;
        hold_off_req = 1'b0;
        req.valid <= 1'b0;
        req.op    <= psg_pkg::OP_WRITE;
        req.data  <= 8'h00;
        rst_n     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero periods expire every tick, all channels silent
        send_tick();
        send_tick();
        send_req(psg_pkg::OP_WRITE, latch_byte(REG_ATT0, 4'h0));
        send_req(psg_pkg::OP_WRITE, latch_byte(REG_ATT1, 4'hF));
        send_req(psg_pkg::OP_WRITE, latch_byte(REG_ATT2, 4'h7));
        send_req(psg_pkg::OP_WRITE, latch_byte(REG_ATT_NOISE, 4'h0));
        send_tick();
        send_tick();
        send_tone_write(0, 4'h0, 7'h00);
        send_tone_write(1, 4'hF, 7'h7F);
        send_tone_write(2, 4'h1, 7'h00);
        send_req(psg_pkg::OP_WRITE, latch_byte(psg_pkg::REG_NOISE_CTRL, 4'h7));
        send_req(psg_pkg::OP_WRITE, 8'h3F);
        send_tick();
        send_tick();
        send_tick();
        send_req(psg_pkg::OP_WRITE, latch_byte(psg_pkg::REG_NOISE_CTRL, 4'h0));
        send_req(OP_UNUSED, 8'hFF);
        send_req(psg_pkg::OP_MUTE, 8'hFF);
        send_tick();
        send_req(psg_pkg::OP_WRITE, latch_byte(REG_ATT2, 4'h0));
        send_req(psg_pkg::OP_WRITE, 8'h05);
        send_tick();

        hold_off_req = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            ch   = $urandom_range(0, psg_pkg::NUM_TONES - 1);
            if (kind < 55) begin
                repeat ($urandom_range(1, 8)) send_tick();
            end else if (kind < 70) begin
                send_tone_write(ch, 4'($urandom_range(0, 15)),
                                ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                            : 7'($urandom_range(0, 3)));
            end else if (kind < 84) begin
                send_req(psg_pkg::OP_WRITE,
                         latch_byte(atten_reg($urandom_range(0, psg_pkg::NUM_CHANS - 1)),
                                    4'($urandom_range(0, 15))));
            end else if (kind < 91) begin
                send_req(psg_pkg::OP_WRITE,
                         latch_byte(psg_pkg::REG_NOISE_CTRL, 4'($urandom_range(0, 15))));
            end else if (kind < 93) begin
                send_req(psg_pkg::OP_MUTE, 8'($urandom_range(0, 255)));
            end else if (kind < 98) begin
                send_req(psg_pkg::OP_WRITE, 8'($urandom_range(0, 255)));
            end else begin
                send_req(OP_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
        req.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d tick requests, %0d samples checked, %0d mismatches",
                 ticks_sent, sb.checked, sb.mismatches);
        $display("summary: tone, attenuation and noise writes, mutes, unused ops, long stall");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
